>>> hw/rtl/swiw_pkg.sv
`timescale 1ns / 1ps
package swiw_pkg;
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_RENDER = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	localparam logic [1:0] REG_AMPLITUDE = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	localparam logic [4:0]  AMPLITUDE_RESET = 5'd6;
	localparam logic [10:0] WIDTH_RESET     = 11'd640;
	localparam logic [9:0]  HEIGHT_RESET    = 10'd480;

	localparam int QUO_W = 14;

	localparam logic [11:0] SIN_C1 = 12'd2320;
	localparam logic [16:0] SIN_C2 = 17'd21024;
	localparam logic [16:0] SIN_C3 = 17'd51472;
	localparam logic [14:0] SIN_MAX = 15'd32767;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_RDW  = 10'b0000000010,
		S_DIV  = 10'b0000000100,
		S_SQ   = 10'b0000001000,
		S_T1   = 10'b0000010000,
		S_T2   = 10'b0000100000,
		S_M    = 10'b0001000000,
		S_SH   = 10'b0010000000,
		S_RUN  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;
endpackage

>>> hw/rtl/sine_wave_image_warp_top.sv
`timescale 1ns / 1ps
// Channel | Handshake                    | Word
// in      | in_valid / in_stall          | kind, column, row, pixel_in, tick
// out     | out_valid / out_stall        | kind_echo, pixel_out
// cfg     | psel, penable, pwrite, pready | paddr, pwdata, prdata
// A load or an unused kind is answered straight from idle; a read passes through S_RDW
// because the output store has a registered read port.
// A render walks the frame twice: per row or column the divider (S_DIV) and the sine steps
// S_SQ, S_T1, S_T2, S_M and S_SH, then one copied pixel per cycle in S_RUN, and S_DONE at the end.
// Reset clears control and loads the configuration reset values; the frame stores are not cleared.
// Input is stalled while an item is in progress or while a result is held by out_stall.
module sine_wave_image_warp_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [9:0]  column,
	input  logic [8:0]  row,
	input  logic [31:0] pixel_in,
	input  logic [11:0] tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind_echo,
	output logic [31:0] pixel_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import swiw_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int LW = $clog2(MAXD + 1);

	logic [31:0] src_mem [DEPTH];
	logic [31:0] shf_mem [DEPTH];
	logic [31:0] out_mem [DEPTH];
	logic [31:0] src_rd_q, shf_rd_q, out_rd_q;

	state_t state_q;
	logic [4:0]  amp_q;
	logic [10:0] wid_q;
	logic [9:0]  hgt_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] pix_q;
	logic [11:0] tick_q;
	logic        rd_in_q;
	logic        pass_q;
	logic [LW-1:0] n_q, k_q;
	logic [LW:0]   rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]  cnt_q;
	logic [15:0] xq_q, x2_q;
	logic        neg_q;
	logic [16:0] t_q;
	logic [15:0] sv_q;
	logic [4:0]  sh_q;
	logic        wv_s1, wpass_s1;
	logic [AW-1:0] waddr_s1;

	logic in_acc, out_acc, cfg_wr, in_store, load_we, empty, out_set;
	logic [LW-1:0] w_eff, h_eff, outer_len, inner_len;
	logic [AW-1:0] ld_addr, run_raddr, run_waddr;
	logic [LW:0] rem2;
	logic [11:0] phase;
	logic [10:0] qv;
	logic [15:0] xq;
	logic [31:0] xsq;
	logic [27:0] p1;
	logic [32:0] p2, p3;
	logic [17:0] mraw;
	logic [14:0] msat;
	logic [19:0] p4;
	logic [LW-1:0] kd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign kind_echo = kind_q;
	assign pixel_out = pix_q;

	always_comb begin
		case (paddr[3:2])
			REG_AMPLITUDE: prdata = {27'd0, amp_q};
			REG_WIDTH:     prdata = {21'd0, wid_q};
			REG_HEIGHT:    prdata = {22'd0, hgt_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign w_eff = (32'(wid_q) > MAX_WIDTH) ? LW'(MAX_WIDTH) : LW'(wid_q);
	assign h_eff = (32'(hgt_q) > MAX_HEIGHT) ? LW'(MAX_HEIGHT) : LW'(hgt_q);
	assign outer_len = pass_q ? w_eff : h_eff;
	assign inner_len = pass_q ? h_eff : w_eff;
	assign empty = (w_eff == '0) || (h_eff == '0);

	assign in_store = (32'(column) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
	assign ld_addr = in_store ? AW'(32'(row) * MAX_WIDTH + 32'(column)) : '0;
	assign load_we = in_acc && (kind == KIND_LOAD) && in_store;

	assign out_set = (state_q == S_RDW) || (state_q == S_DONE) ||
	                 ((state_q == S_IDLE) && in_acc && (kind != KIND_READ) &&
	                  !((kind == KIND_RENDER) && !empty));

	assign kd = k_q - LW'(sh_q);
	assign run_raddr = pass_q ? AW'(32'(kd) * MAX_WIDTH + 32'(n_q))
	                          : AW'(32'(n_q) * MAX_WIDTH + 32'(kd));
	assign run_waddr = pass_q ? AW'(32'(k_q) * MAX_WIDTH + 32'(n_q))
	                          : AW'(32'(n_q) * MAX_WIDTH + 32'(k_q));

	assign rem2 = {rem_q[LW-1:0], 1'b0};
	assign phase = quo_q[11:0] + tick_q;
	assign qv = phase[10] ? (11'd1024 - {1'b0, phase[9:0]}) : {1'b0, phase[9:0]};
	assign xq = {qv[10:0], 5'd0};
	assign xsq = 32'(xq) * 32'(xq);
	assign p1 = 28'(SIN_C1) * 28'(x2_q);
	assign p2 = 33'(SIN_C2 - t_q) * 33'(x2_q);
	assign p3 = 33'(SIN_C3 - t_q) * 33'(xq_q);
	assign mraw = p3[32:15];
	assign msat = (mraw > 18'(SIN_MAX)) ? SIN_MAX : mraw[14:0];
	assign p4 = 20'(amp_q[4:1]) * 20'(sv_q);

	always_ff @(posedge clk) begin
		if (load_we) begin
			src_mem[ld_addr] <= pixel_in;
		end
		src_rd_q <= src_mem[run_raddr];
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			shf_mem[ld_addr] <= pixel_in;
		end else if (wv_s1 && !wpass_s1) begin
			shf_mem[waddr_s1] <= src_rd_q;
		end
		shf_rd_q <= shf_mem[run_raddr];
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			out_mem[ld_addr] <= pixel_in;
		end else if (wv_s1 && wpass_s1) begin
			out_mem[waddr_s1] <= shf_rd_q;
		end
		out_rd_q <= out_mem[ld_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= AMPLITUDE_RESET;
			wid_q <= WIDTH_RESET;
			hgt_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_AMPLITUDE: amp_q <= pwdata[4:0];
				REG_WIDTH:     wid_q <= pwdata[10:0];
				REG_HEIGHT:    hgt_q <= pwdata[9:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= run_waddr;
		wpass_s1 <= pass_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wv_s1 <= 1'b0;
			pass_q <= 1'b0;
		end else begin
			wv_s1 <= (state_q == S_RUN) && (k_q < inner_len);
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						kind_q <= kind;
						tick_q <= tick;
						pix_q <= 32'd0;
						rd_in_q <= in_store;
						if (kind == KIND_READ) begin
							state_q <= S_RDW;
						end else if (kind == KIND_RENDER && !empty) begin
							pass_q <= 1'b0;
							n_q <= '0;
							rem_q <= '0;
							cnt_q <= 4'(QUO_W - 1);
							state_q <= S_DIV;
						end
					end
				end
				S_RDW: begin
					pix_q <= rd_in_q ? out_rd_q : 32'd0;
					state_q <= S_IDLE;
				end
				S_DIV: begin
					if (rem2 >= {1'b0, outer_len}) begin
						rem_q <= rem2 - {1'b0, outer_len};
						quo_q <= {quo_q[QUO_W-2:0], 1'b1};
					end else begin
						rem_q <= rem2;
						quo_q <= {quo_q[QUO_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					xq_q <= xq;
					x2_q <= xsq[30:15];
					neg_q <= phase[11];
					state_q <= S_T1;
				end
				S_T1: begin
					t_q <= 17'(p1[27:15]);
					state_q <= S_T2;
				end
				S_T2: begin
					t_q <= p2[31:15];
					state_q <= S_M;
				end
				S_M: begin
					sv_q <= neg_q ? (16'h8000 - 16'(msat)) : (16'h8000 + 16'(msat));
					state_q <= S_SH;
				end
				S_SH: begin
					sh_q <= p4[19:15];
					k_q <= LW'(p4[19:15]);
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (k_q < inner_len) begin
						k_q <= k_q + LW'(1);
					end else if (n_q + LW'(1) == outer_len) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							n_q <= '0;
							rem_q <= '0;
							cnt_q <= 4'(QUO_W - 1);
							state_q <= S_DIV;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						n_q <= n_q + LW'(1);
						rem_q <= {1'b0, n_q + LW'(1)};
						cnt_q <= 4'(QUO_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input accepted while an item is in progress");
	a_write_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> $past(state_q == S_RUN))
		else $error("frame copy write outside the copy phase");
	a_no_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_RUN) |-> !$rose(out_valid_q))
		else $error("result raised during a render");
`endif
endmodule

>>> tb/sv/tb_sine_wave_image_warp_top.sv
`timescale 1ns / 1ps
module tb_sine_wave_image_warp_top;
	import swiw_pkg::*;

	localparam int STORE_W = 1024;
	localparam int STORE_H = 512;
	localparam int STALL_LIMIT = 200000;

	class ripple_scoreboard;
		bit [31:0] src_px [STORE_W*STORE_H];
		bit [31:0] mid_px [STORE_W*STORE_H];
		bit [31:0] out_px [STORE_W*STORE_H];
		bit src_ok [STORE_W*STORE_H];
		bit mid_ok [STORE_W*STORE_H];
		bit out_ok [STORE_W*STORE_H];
		logic [4:0] amp;
		logic [10:0] fw;
		logic [9:0] fh;
		logic [1:0] exp_kind [$];
		logic [31:0] exp_pixel [$];
		int errors;

		function new();
			amp = AMPLITUDE_RESET;
			fw = WIDTH_RESET;
			fh = HEIGHT_RESET;
			errors = 0;
		endfunction

		task flag(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		function int sine_q15(int unsigned phase);
			int unsigned p;
			longint unsigned q, xq, x2, t, m;
			p = phase & 4095;
			q = ((p >> 10) & 1) ? 1024 - (p & 1023) : (p & 1023);
			xq = q << 5;
			x2 = (xq * xq) >> 15;
			t = (2320 * x2) >> 15;
			t = ((21024 - t) * x2) >> 15;
			m = ((51472 - t) * xq) >> 15;
			if (m > 32767)
				m = 32767;
			return ((p >> 10) & 2) ? -int'(m) : int'(m);
		endfunction

		function int unsigned ripple_offset(int unsigned n, int unsigned len,
			int unsigned tk, int unsigned half);
			int unsigned base;
			longint unsigned v;
			base = (n << 14) / len;
			v = longint'(half) * longint'(32768 + sine_q15(base + tk));
			return v >> 15;
		endfunction

		function void render_ripple(int unsigned tk);
			int unsigned w, h, half, sh, a, b;
			w = (fw > STORE_W) ? STORE_W : fw;
			h = (fh > STORE_H) ? STORE_H : fh;
			half = amp >> 1;
			if (w == 0 || h == 0)
				return;
			for (int unsigned y = 0; y < h; y++) begin
				sh = ripple_offset(y, h, tk, half);
				for (int unsigned x = sh; x < w; x++) begin
					a = y * STORE_W + x;
					mid_px[a] = src_px[a - sh];
					mid_ok[a] = src_ok[a - sh];
				end
			end
			for (int unsigned x = 0; x < w; x++) begin
				sh = ripple_offset(x, w, tk, half);
				for (int unsigned y = sh; y < h; y++) begin
					a = y * STORE_W + x;
					b = (y - sh) * STORE_W + x;
					out_px[a] = mid_px[b];
					out_ok[a] = mid_ok[b];
				end
			end
		endfunction

		function void note_word(logic [1:0] k, logic [9:0] c, logic [8:0] r,
			logic [31:0] pix, logic [11:0] tk);
			int unsigned a;
			logic [31:0] res;
			a = r * STORE_W + c;
			res = '0;
			case (k)
				KIND_LOAD: begin
					src_px[a] = pix; mid_px[a] = pix; out_px[a] = pix;
					src_ok[a] = 1; mid_ok[a] = 1; out_ok[a] = 1;
				end
				KIND_RENDER: render_ripple(tk);
				KIND_READ: res = out_px[a];
				default: ;
			endcase
			exp_kind.push_back(k);
			exp_pixel.push_back(res);
		endfunction

		task check_word(logic [1:0] k, logic [31:0] pix);
			logic [1:0] wk;
			logic [31:0] wp;
			if (exp_kind.size() == 0) begin
				flag("unexpected word", {30'b0, k}, 32'b0);
				return;
			end
			wk = exp_kind.pop_front();
			wp = exp_pixel.pop_front();
			if (k !== wk)
				flag("kind_echo", {30'b0, k}, {30'b0, wk});
			if (pix !== wp)
				flag("pixel_out", pix, wp);
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] kind, kind_echo;
	logic [9:0] column;
	logic [8:0] row;
	logic [31:0] pixel_in, pixel_out;
	logic [11:0] tick;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	ripple_scoreboard sb;
	int send_idle_pct, recv_idle_pct;
	int accepted;
	int quiet_cycles = 0;
	logic hold_out;

	sine_wave_image_warp_top i_dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk)
		out_stall <= hold_out || ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_word(kind_echo, pixel_out);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		hold_out <= 1'b0;
		wait (accepted >= 300);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (400) @(posedge clk);
		hold_out <= 1'b0;
	end

	task automatic send_word(logic [1:0] k, logic [9:0] c, logic [8:0] r,
		logic [31:0] pix, logic [11:0] tk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k; column <= c; row <= r; pixel_in <= pix; tick <= tk;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(k, c, r, pix, tk);
		accepted++;
		if (accepted == 600) begin
			send_idle_pct = 66; recv_idle_pct = 28;
		end else if (accepted == 1200) begin
			send_idle_pct = 0; recv_idle_pct = 0;
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.exp_kind.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_frame(logic [4:0] a, logic [10:0] w, logic [9:0] h);
		drain();
		write_reg(REG_AMPLITUDE, 32'(a));
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
		sb.amp = a; sb.fw = w; sb.fh = h;
	endtask

	task automatic read_or_load();
		int unsigned c, r;
		c = $urandom_range(sb.fw - 1);
		r = $urandom_range(sb.fh - 1);
		for (int i = 0; i < 20 && !sb.out_ok[r * STORE_W + c]; i++) begin
			c = $urandom_range(sb.fw - 1);
			r = $urandom_range(sb.fh - 1);
		end
		if (sb.out_ok[r * STORE_W + c])
			send_word(KIND_READ, c, r, $urandom, $urandom);
		else
			send_word(KIND_LOAD, c, r, $urandom, $urandom);
	endtask

	task automatic random_words(int n, bit renders);
		int unsigned pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				send_word(KIND_LOAD, $urandom_range(sb.fw - 1), $urandom_range(sb.fh - 1),
					$urandom, $urandom);
			else if (pick < 84)
				read_or_load();
			else if (pick < 89)
				send_word(2'd3, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 95)
				send_word(KIND_LOAD, $urandom, $urandom, $urandom, $urandom);
			else if (renders)
				send_word(KIND_RENDER, $urandom, $urandom, $urandom, $urandom);
			else
				read_or_load();
		end
	endtask

	task automatic fill_frame();
		for (int r = 0; r < sb.fh; r++)
			for (int c = 0; c < sb.fw; c++)
				send_word(KIND_LOAD, c, r, $urandom, $urandom);
	endtask

	initial begin
		sb = new();
		accepted = 0;
		send_idle_pct = 28;
		recv_idle_pct = 66;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0; column = '0; row = '0; pixel_in = '0; tick = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		random_words(120, 0);

		set_frame(5'd5, 11'd17, 10'd17);
		fill_frame();
		send_word(KIND_LOAD, 10'd0, 9'd0, 32'h0, 12'h0);
		send_word(KIND_LOAD, 10'd1023, 9'd511, 32'hFFFFFFFF, 12'hFFF);
		send_word(KIND_LOAD, 10'd16, 9'd16, 32'hA5A5A5A5, 12'h0);
		send_word(KIND_READ, 10'd1023, 9'd511, 32'h0, 12'h0);
		send_word(KIND_READ, 10'd0, 9'd0, 32'hFFFFFFFF, 12'hFFF);
		send_word(KIND_READ, 10'd16, 9'd16, 32'h0, 12'h0);
		send_word(2'd3, 10'd1023, 9'd511, 32'hFFFFFFFF, 12'hFFF);
		send_word(KIND_RENDER, 10'd0, 9'd0, 32'h0, 12'd0);
		send_word(KIND_RENDER, 10'd0, 9'd0, 32'h0, 12'd1024);
		send_word(KIND_RENDER, 10'd0, 9'd0, 32'h0, 12'd2048);
		send_word(KIND_RENDER, 10'd1023, 9'd511, 32'hFFFFFFFF, 12'd4095);
		for (int i = 0; i < 10; i++)
			read_or_load();
		random_words(300, 1);

		set_frame(5'd16, 11'd1024, 10'd17);
		random_words(200, 0);
		send_word(KIND_RENDER, $urandom, $urandom, $urandom, 12'd0);
		random_words(120, 0);

		set_frame(5'd9, 11'd17, 10'd512);
		random_words(200, 0);
		send_word(KIND_RENDER, $urandom, $urandom, $urandom, $urandom);
		random_words(120, 0);

		set_frame(5'd12, 11'd30, 10'd20);
		random_words(150, 1);

		set_frame(5'd16, 11'd17, 10'd17);
		random_words(150, 1);

		drain();
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
